[rtl/plcs_pkg.sv]
package plcs_pkg;

   // field widths of the channels
   localparam int POS_W      = 32;
   localparam int QUAT_W     = 16;
   localparam int POSE_IDX_W = 10;
   localparam int WORD_IDX_W = 5;
   localparam int MATCH_W    = 32;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_CFG_W = 11;
   localparam int DIST_W     = 31;
   localparam int COS_W      = 16;

   localparam logic [CSR_IDX_W-1:0] REG_RECORD_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_GAP        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_USE_ANGLE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COS_HALF_ANGLE = 3'd4;

   localparam logic [COUNT_CFG_W-1:0] RECORD_SIZE_RESET = 11'd1024;
   localparam logic [COUNT_CFG_W-1:0] MIN_GAP_RESET     = 11'd1;
   localparam logic [COS_W-1:0]       COS_RESET         = 16'd32768;

   // one stored pose
   typedef struct packed {
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic signed [POS_W-1:0]  z;
      logic signed [QUAT_W-1:0] qw;
      logic signed [QUAT_W-1:0] qx;
      logic signed [QUAT_W-1:0] qy;
      logic signed [QUAT_W-1:0] qz;
   } pose_type;

   // operand selection of the shared multiplier
   typedef logic [3:0] mul_sel_type;

   localparam mul_sel_type MUL_IDLE = 4'd0;
   localparam mul_sel_type MUL_LIM  = 4'd1;
   localparam mul_sel_type MUL_X    = 4'd2;
   localparam mul_sel_type MUL_Y    = 4'd3;
   localparam mul_sel_type MUL_Z    = 4'd4;
   localparam mul_sel_type MUL_QW   = 4'd5;
   localparam mul_sel_type MUL_QX   = 4'd6;
   localparam mul_sel_type MUL_QY   = 4'd7;
   localparam mul_sel_type MUL_QZ   = 4'd8;

   typedef struct packed {
      logic signed [63:0] prod;
      logic               far;
   } mul_res_type;

endpackage

[rtl/plcs_ifs.sv]
interface plcs_req_if
   import plcs_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;
   logic signed [QUAT_W-1:0] quat_w;
   logic signed [QUAT_W-1:0] quat_x;
   logic signed [QUAT_W-1:0] quat_y;
   logic signed [QUAT_W-1:0] quat_z;

   modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                   output ready);
endinterface

interface plcs_rsp_if
   import plcs_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [POSE_IDX_W-1:0] pose_index;
   logic [WORD_IDX_W-1:0] word_index;
   logic [MATCH_W-1:0]    match_bits;
   logic                  last;
   logic                  ignored;

   modport source (output valid, pose_index, word_index, match_bits, last, ignored,
                   input ready);
   modport sink   (input valid, pose_index, word_index, match_bits, last, ignored,
                   output ready);
endinterface

interface plcs_csr_if
   import plcs_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/plcs_mul.sv]
module plcs_mul
   import plcs_pkg::*;
(
   input  logic             clock,
   input  mul_sel_type      sel,
   input  pose_type         cur,
   input  pose_type         rd,
   input  logic [DIST_W-1:0] radius,
   output mul_res_type      res
);

   logic signed [POS_W-1:0] cur_axis;
   logic signed [POS_W-1:0] rd_axis;
   logic signed [POS_W:0]   diff;
   logic [POS_W:0]          diff_mag;
   logic signed [31:0]      op_a;
   logic signed [31:0]      op_b;
   logic                    far_in;
   logic signed [63:0]      prod_ff;
   logic                    far_ff;

   // pick the axis for a distance step
   always_comb begin
      unique case (sel)
         MUL_Y: begin
            cur_axis = cur.y;
            rd_axis  = rd.y;
         end
         MUL_Z: begin
            cur_axis = cur.z;
            rd_axis  = rd.z;
         end
         default: begin
            cur_axis = cur.x;
            rd_axis  = rd.x;
         end
      endcase
   end

   // difference and its magnitude; a magnitude of 2^31 or more can never match
   assign diff     = {cur_axis[POS_W-1], cur_axis} - {rd_axis[POS_W-1], rd_axis};
   assign diff_mag = diff[POS_W] ? (-diff) : diff;

   // select operands
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      far_in = 1'b0;
      unique case (sel)
         MUL_LIM: begin
            op_a = {1'b0, radius};
            op_b = {1'b0, radius};
         end
         MUL_X, MUL_Y, MUL_Z: begin
            op_a   = {1'b0, diff_mag[POS_W-2:0]};
            op_b   = {1'b0, diff_mag[POS_W-2:0]};
            far_in = diff_mag[POS_W] | diff_mag[POS_W-1];
         end
         MUL_QW: begin
            op_a = {{16{cur.qw[QUAT_W-1]}}, cur.qw};
            op_b = {{16{rd.qw[QUAT_W-1]}}, rd.qw};
         end
         MUL_QX: begin
            op_a = {{16{cur.qx[QUAT_W-1]}}, cur.qx};
            op_b = {{16{rd.qx[QUAT_W-1]}}, rd.qx};
         end
         MUL_QY: begin
            op_a = {{16{cur.qy[QUAT_W-1]}}, cur.qy};
            op_b = {{16{rd.qy[QUAT_W-1]}}, rd.qy};
         end
         MUL_QZ: begin
            op_a = {{16{cur.qz[QUAT_W-1]}}, cur.qz};
            op_b = {{16{rd.qz[QUAT_W-1]}}, rd.qz};
         end
         default: begin
            op_a   = '0;
            op_b   = '0;
            far_in = 1'b0;
         end
      endcase
   end

   // register the product
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      far_ff  <= far_in;
   end

   assign res.prod = prod_ff;
   assign res.far  = far_ff;

endmodule

[rtl/pose_loop_candidate_search.sv]
// Channel   Dir  Handshake        Payload
// req_bus   in   valid / ready    pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
// rsp_bus   out  valid / ready    pose_index, word_index, match_bits, last, ignored
// csr_bus   in   valid / ready=1  index, data
//
// A pose squares the radius (ST_LIM, ST_LIMST), then walks the earlier indices: one
// outside the compared range is flagged in ST_CHECK, a compared one passes ST_DX to
// ST_DCMP, then ST_Q1 to ST_QCMP if the position test passes and use_angle is set,
// all on the one shared 32x32 multiplier; words end in ST_EMIT. Ignored poses: ST_IGN.
// Reset is synchronous and clears control and configuration; the pose store is not
// cleared. A result word waits in the output register; the walk stalls at the end of
// the next word until that transfer completes. req_bus.ready is high only when idle.
module pose_loop_candidate_search
   import plcs_pkg::*;
#(
   parameter int MAX_POSES = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   plcs_req_if.sink   req_bus,
   plcs_rsp_if.source rsp_bus,
   plcs_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(MAX_POSES);
   localparam int CW = $clog2(MAX_POSES + 1);
   localparam int IW = $clog2(MAX_POSES + WORD_BITS);
   localparam int KW = $clog2(WORD_BITS);
   localparam int WW = $clog2((MAX_POSES + WORD_BITS - 1) / WORD_BITS + 1);
   localparam int XW = ((IW > COUNT_CFG_W) ? IW : COUNT_CFG_W) + 1;
   localparam logic [KW-1:0] K_LAST = KW'(WORD_BITS - 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LIM   = 4'd1;
   localparam logic [3:0] ST_LIMST = 4'd2;
   localparam logic [3:0] ST_CHECK = 4'd3;
   localparam logic [3:0] ST_DX    = 4'd4;
   localparam logic [3:0] ST_DY    = 4'd5;
   localparam logic [3:0] ST_DZ    = 4'd6;
   localparam logic [3:0] ST_DCMP  = 4'd7;
   localparam logic [3:0] ST_Q1    = 4'd8;
   localparam logic [3:0] ST_Q2    = 4'd9;
   localparam logic [3:0] ST_Q3    = 4'd10;
   localparam logic [3:0] ST_QCMP  = 4'd11;
   localparam logic [3:0] ST_EMIT  = 4'd12;
   localparam logic [3:0] ST_IGN   = 4'd13;

   // configuration
   logic [COUNT_CFG_W-1:0] rec_size_ff;
   logic [COUNT_CFG_W-1:0] gap_ff;
   logic [DIST_W-1:0]      radius_ff;
   logic                   use_angle_ff;
   logic [COS_W-1:0]       cos_ff;

   // control
   logic [3:0]     state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  cur_i_ff, cur_i_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [WW-1:0]  w_ff, w_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // datapath
   pose_type               cur_ff, cur_in;
   pose_type               rd_ff;
   pose_type               pose_in;
   logic [61:0]            lim_ff, lim_in;
   logic [63:0]            acc_ff, acc_in;
   logic                   far_ff, far_in;
   logic signed [34:0]     dot_ff, dot_in;
   logic [WORD_BITS-1:0]   bits_ff, bits_in;
   logic [POSE_IDX_W-1:0]  out_pose_ff, out_pose_in;
   logic [WORD_IDX_W-1:0]  out_word_ff, out_word_in;
   logic [MATCH_W-1:0]     out_bits_ff, out_bits_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_ign_ff, out_ign_in;

   pose_type store_mem [MAX_POSES];

   mul_sel_type mul_sel;
   mul_res_type mul_res;

   logic               req_fire;
   logic               full;
   logic               compared;
   logic               out_free;
   logic               bit_done;
   logic               bit_val;
   logic [63:0]        prod_u;
   logic signed [34:0] prod_lo;
   logic [63:0]        dsum;
   logic               dist_ok;
   logic signed [34:0] qsum;
   logic [34:0]        qmag;
   logic               angle_ok;
   logic [15:0]        cur_i_wide;
   logic [15:0]        w_wide;
   logic [63:0]        bits_wide;

   assign req_fire       = req_bus.valid && req_bus.ready;
   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign csr_bus.ready  = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;

   assign pose_in.x  = req_bus.pos_x;
   assign pose_in.y  = req_bus.pos_y;
   assign pose_in.z  = req_bus.pos_z;
   assign pose_in.qw = req_bus.quat_w;
   assign pose_in.qx = req_bus.quat_x;
   assign pose_in.qy = req_bus.quat_y;
   assign pose_in.qz = req_bus.quat_z;

   // record full once the count reaches the record size or the store depth
   assign full = (XW'(count_ff) >= XW'(rec_size_ff)) || (XW'(count_ff) >= XW'(MAX_POSES));

   // earlier pose lies in the compared range
   assign compared = (cur_i_ff != '0) && (XW'(idx_ff) <= XW'(cur_i_ff)) &&
                     ((XW'(idx_ff) + XW'(gap_ff)) <= XW'(cur_i_ff));

   // threshold tests
   assign prod_u   = $unsigned(mul_res.prod);
   assign prod_lo  = mul_res.prod[34:0];
   assign dsum     = acc_ff + prod_u;
   assign dist_ok  = !(far_ff || mul_res.far) && (dsum < {2'b00, lim_ff});
   assign qsum     = dot_ff + prod_lo;
   assign qmag     = qsum[34] ? $unsigned(-qsum) : $unsigned(qsum);
   assign angle_ok = qmag > {4'b0000, cos_ff, 15'b0};

   assign cur_i_wide = 16'(cur_i_ff);
   assign w_wide     = 16'(w_ff);
   assign bits_wide  = 64'(bits_ff);

   plcs_mul u_mul (
      .clock    (clock),
      .sel      (mul_sel),
      .cur      (cur_ff),
      .rd       (rd_ff),
      .radius   (radius_ff),
      .res      (mul_res)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_i_in     = cur_i_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      cur_in       = cur_ff;
      lim_in       = lim_ff;
      acc_in       = acc_ff;
      far_in       = far_ff;
      dot_in       = dot_ff;
      bits_in      = bits_ff;
      out_pose_in  = out_pose_ff;
      out_word_in  = out_word_ff;
      out_bits_in  = out_bits_ff;
      out_last_in  = out_last_ff;
      out_ign_in   = out_ign_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mul_sel      = MUL_IDLE;
      bit_done     = 1'b0;
      bit_val      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (full) begin
                  state_in = ST_IGN;
               end else begin
                  cur_in   = pose_in;
                  cur_i_in = count_ff;
                  count_in = count_ff + 1'b1;
                  idx_in   = '0;
                  k_in     = '0;
                  w_in     = '0;
                  bits_in  = '0;
                  state_in = ST_LIM;
               end
            end
         end
         ST_LIM: begin
            mul_sel  = MUL_LIM;
            state_in = ST_LIMST;
         end
         ST_LIMST: begin
            lim_in   = prod_u[61:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (compared) begin
               state_in = ST_DX;
            end else begin
               bit_done = 1'b1;
            end
         end
         ST_DX: begin
            mul_sel  = MUL_X;
            state_in = ST_DY;
         end
         ST_DY: begin
            mul_sel  = MUL_Y;
            acc_in   = prod_u;
            far_in   = mul_res.far;
            state_in = ST_DZ;
         end
         ST_DZ: begin
            mul_sel  = MUL_Z;
            acc_in   = acc_ff + prod_u;
            far_in   = far_ff || mul_res.far;
            state_in = ST_DCMP;
         end
         ST_DCMP: begin
            // start the orientation product in case it is needed
            mul_sel = MUL_QW;
            if (dist_ok && use_angle_ff) begin
               state_in = ST_Q1;
            end else begin
               bit_done = 1'b1;
               bit_val  = dist_ok;
            end
         end
         ST_Q1: begin
            mul_sel  = MUL_QX;
            dot_in   = prod_lo;
            state_in = ST_Q2;
         end
         ST_Q2: begin
            mul_sel  = MUL_QY;
            dot_in   = dot_ff + prod_lo;
            state_in = ST_Q3;
         end
         ST_Q3: begin
            mul_sel  = MUL_QZ;
            dot_in   = dot_ff + prod_lo;
            state_in = ST_QCMP;
         end
         ST_QCMP: begin
            bit_done = 1'b1;
            bit_val  = angle_ok;
         end
         ST_EMIT: begin
            // hand the finished word over once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_pose_in  = cur_i_wide[POSE_IDX_W-1:0];
               out_word_in  = w_wide[WORD_IDX_W-1:0];
               out_bits_in  = bits_wide[MATCH_W-1:0];
               out_last_in  = (XW'(idx_ff) >= XW'(cur_i_ff));
               out_ign_in   = 1'b0;
               if (XW'(idx_ff) >= XW'(cur_i_ff)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  k_in     = '0;
                  w_in     = w_ff + 1'b1;
                  bits_in  = '0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_IGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_pose_in  = '0;
               out_word_in  = '0;
               out_bits_in  = '0;
               out_last_in  = 1'b1;
               out_ign_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // record the flag and advance to the next earlier pose
      if (bit_done) begin
         bits_in[k_ff] = bit_val;
         if (k_ff == K_LAST) begin
            state_in = ST_EMIT;
         end else begin
            k_in     = k_ff + 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_CHECK;
         end
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rec_size_ff  <= RECORD_SIZE_RESET;
         gap_ff       <= MIN_GAP_RESET;
         radius_ff    <= '0;
         use_angle_ff <= 1'b0;
         cos_ff       <= COS_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_bus.index)
               REG_RECORD_SIZE:    rec_size_ff  <= csr_bus.data[COUNT_CFG_W-1:0];
               REG_MIN_GAP:        gap_ff       <= csr_bus.data[COUNT_CFG_W-1:0];
               REG_RADIUS:         radius_ff    <= csr_bus.data[DIST_W-1:0];
               REG_USE_ANGLE:      use_angle_ff <= csr_bus.data[0];
               REG_COS_HALF_ANGLE: cos_ff       <= csr_bus.data[COS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_i_ff    <= cur_i_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      w_ff        <= w_in;
      cur_ff      <= cur_in;
      lim_ff      <= lim_in;
      acc_ff      <= acc_in;
      far_ff      <= far_in;
      dot_ff      <= dot_in;
      bits_ff     <= bits_in;
      out_pose_ff <= out_pose_in;
      out_word_ff <= out_word_in;
      out_bits_ff <= out_bits_in;
      out_last_ff <= out_last_in;
      out_ign_ff  <= out_ign_in;
   end

   // pose store: write the accepted pose, read the walked index
   always_ff @(posedge clock) begin
      if (req_fire && !full) begin
         store_mem[count_ff[AW-1:0]] <= pose_in;
      end
      rd_ff <= store_mem[idx_ff[AW-1:0]];
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pose_index = out_pose_ff;
   assign rsp_bus.word_index = out_word_ff;
   assign rsp_bus.match_bits = out_bits_ff;
   assign rsp_bus.last       = out_last_ff;
   assign rsp_bus.ignored    = out_ign_ff;

endmodule

[rtl/plcs_checker.sv]
module plcs_checker
   import plcs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [POSE_IDX_W-1:0] rsp_pose_index,
   input logic [WORD_IDX_W-1:0] rsp_word_index,
   input logic [MATCH_W-1:0]    rsp_match_bits,
   input logic                  rsp_last,
   input logic                  rsp_ignored
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_match_bits) && $stable(rsp_word_index) &&
                                  $stable(rsp_last) && $stable(rsp_pose_index))
      else $error("stalled result changed");

   // an ignored pose gives a single empty word
   a_ignored_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_last && (rsp_match_bits == '0) &&
                                   (rsp_pose_index == '0) && (rsp_word_index == '0))
      else $error("ignored result not empty");

   // one pose at a time: busy after every transfer in
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after an input transfer");

endmodule

bind pose_loop_candidate_search plcs_checker u_plcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_pose_index (rsp_bus.pose_index),
   .rsp_word_index (rsp_bus.word_index),
   .rsp_match_bits (rsp_bus.match_bits),
   .rsp_last       (rsp_bus.last),
   .rsp_ignored    (rsp_bus.ignored)
);
